// ===== src/bega_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bega_pkg;

    // Table and sample geometry.
    localparam int MAX_POINTS      = 64;
    localparam int PIDX_BITS       = $clog2(MAX_POINTS);
    localparam int CNT_BITS        = 7;
    localparam int TIME_BITS       = 32;
    localparam int VAL_BITS        = 16;
    localparam int INT_BITS        = 16;
    localparam int SAMPLE_BITS     = 24;
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int KIDX_BITS       = SINE_TABLE_BITS + 1;

    // Quotient width of the interpolation divide; the quotient magnitude is
    // bounded by the value step, which is below 2^17.
    localparam int QBITS    = VAL_BITS + 1;
    localparam int QCNT_BITS = $clog2(QBITS);

    // Configuration port.
    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_INTENSITY = 2'd1;
    localparam logic [1:0] REG_COUNT     = 2'd2;

    localparam logic [INT_BITS-1:0] INTENSITY_RESET = 16'd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_CHKL,
        S_SCAN,
        S_MULT,
        S_ABS,
        S_DIV,
        S_SCALE,
        S_GAIN,
        S_PROD,
        S_OUT
    } state_t;

    typedef logic [15:0] sine_tab_t [0:SINE_N];

    // Quarter-wave sine in Q1.15 from an integer Taylor series on a Q30 angle.
    function automatic logic [15:0] sine_q15(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (64'(j) * 64'd1686629713) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(64'd1 << 30))
            sum = longint'(64'd1 << 30);
        return 16'((64'(sum) + 64'd16384) >> 15);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int j = 0; j <= SINE_N; j++)
        begin
            tab[j] = sine_q15(j);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== src/breakpoint_envelope_gain_pan.sv =====
// Breakpoint envelope with amplitude gain or equal-power panning.
// Input channel (in_valid / in_stall): each item either writes one breakpoint
// (req_type 0) into the time and value memories, or processes one stereo
// frame (req_type 1). A breakpoint write produces no output item; a frame
// produces exactly one output item on out_valid / out_stall.
// Configuration (mode, intensity, point_count) is written over the APB port
// at byte addresses 0, 4 and 8; the user must write it only while the block
// is idle. The block itself does not enforce this.
// A breakpoint write is stored on acceptance. A frame with no points goes to
// the gain product; otherwise it reads the first and last breakpoints, scans
// up to 63 breakpoints for the segment, interpolating by bit-serial divide.
// One item is worked on at a time; the next item is accepted as soon as the
// current one has reached the output register, even while that is stalled.
// When the receiver stalls, the finished item waits in the output register
// and a following frame waits in its last stage.
// Reset clears the state, mode, point count, frame index and handshake and
// sets intensity to 16384; the datapath registers hold no reset value, and
// breakpoint memories hold no reset value and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_envelope_gain_pan
    import bega_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic [PIDX_BITS-1:0]          point_index,
    input  wire logic [TIME_BITS-1:0]          point_time,
    input  wire logic signed [VAL_BITS-1:0]    point_value,
    input  wire logic                          restart,
    input  wire logic signed [SAMPLE_BITS-1:0] left_in,
    input  wire logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      left_out,
    output logic signed [SAMPLE_BITS-1:0]      right_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_BITS-1:0]          paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int PROD_BITS = SAMPLE_BITS + 20;

    // Control state.
    state_t                  state_reg, state_next;
    logic                    mode_reg;
    logic [INT_BITS-1:0]     intensity_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic [TIME_BITS-1:0]    frame_reg;
    logic                    out_valid_reg;

    // Datapath registers.
    logic [TIME_BITS-1:0]         cur_t_reg;
    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic [TIME_BITS-1:0]         prev_t_reg;
    logic signed [VAL_BITS-1:0]   prev_v_reg, last_v_reg;
    logic [PIDX_BITS-1:0]         scan_idx_reg;
    logic [TIME_BITS-1:0]         d_reg, dt_reg;
    logic signed [VAL_BITS:0]     dv_reg;
    logic signed [TIME_BITS+VAL_BITS+1:0] num_reg;
    logic                         neg_reg;
    logic [TIME_BITS-1:0]         rem_reg;
    logic [QBITS-1:0]             low_reg, q_reg;
    logic [QCNT_BITS-1:0]         div_cnt_reg;
    logic signed [VAL_BITS:0]     env_reg;
    logic signed [34:0]           scale_reg;
    logic signed [19:0]           gain_l_reg, gain_r_reg;
    logic                         sh15_reg;
    logic signed [PROD_BITS-1:0]  prod_l_reg, prod_r_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    // Breakpoint memories.
    logic [TIME_BITS-1:0]       time_mem [0:MAX_POINTS-1];
    logic signed [VAL_BITS-1:0] val_mem  [0:MAX_POINTS-1];
    logic [TIME_BITS-1:0]       rd_t;
    logic signed [VAL_BITS-1:0] rd_v;
    logic [PIDX_BITS-1:0]       mem_addr;

    logic                   in_acc, frame_acc, wr_acc, cfg_wr;
    logic [CNT_BITS-1:0]    n_eff;
    logic [PIDX_BITS-1:0]   nm1;
    logic [TIME_BITS-1:0]   t_now;
    logic                   seg_hit;
    logic [TIME_BITS:0]     rem_sh;
    logic                   div_ge;
    logic [TIME_BITS:0]     rem_diff;
    logic [QBITS-1:0]       q_next;
    logic signed [QBITS:0]  q_signed;
    logic signed [VAL_BITS:0] env_div;
    logic signed [TIME_BITS+VAL_BITS+1:0] num_abs;
    logic signed [34:0]     p_clamp;
    logic [27:0]            p_off;
    logic [KIDX_BITS-1:0]   k_raw, k_idx;
    logic signed [19:0]     amp_gain;
    logic signed [PROD_BITS-1:0] rnd_l, rnd_r, sh_l, sh_r;
    logic                   out_free;

    // Handshake and configuration decode.
    assign in_acc    = in_valid && !in_stall;
    assign frame_acc = in_acc && req_type;
    assign wr_acc    = in_acc && !req_type;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign n_eff = (count_reg > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : count_reg;
    assign nm1   = PIDX_BITS'(n_eff - 1'b1);
    assign t_now = restart ? '0 : frame_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:      prdata = {31'd0, mode_reg};
            REG_INTENSITY: prdata = {16'd0, intensity_reg};
            REG_COUNT:     prdata = {25'd0, count_reg};
            default:       prdata = '0;
        endcase
    end

    // Segment test and one restoring-divide step.
    assign seg_hit  = (cur_t_reg >= prev_t_reg) && (cur_t_reg <= rd_t);
    assign rem_sh   = {rem_reg, low_reg[QBITS-1]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign div_ge   = rem_sh >= {1'b0, d_reg};
    assign q_next   = {q_reg[QBITS-2:0], div_ge};
    assign q_signed = neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
    assign env_div  = (VAL_BITS+1)'(prev_v_reg + q_signed);
    assign num_abs  = (num_reg < 0) ? -num_reg : num_reg;

    // Gain derivation from the scaled envelope.
    assign amp_gain = 20'(35'sd4096 + ((scale_reg + 35'sd8192) >>> 14));
    assign p_clamp  = (scale_reg > 35'sd67108864) ? 35'sd67108864 :
                      (scale_reg < -35'sd67108864) ? -35'sd67108864 : scale_reg;
    assign p_off    = 28'(p_clamp + 35'sd67108864);
    assign k_raw    = KIDX_BITS'((p_off + 28'(1 << (26 - SINE_TABLE_BITS)))
                      >> (27 - SINE_TABLE_BITS));
    assign k_idx    = (k_raw > KIDX_BITS'(SINE_N)) ? KIDX_BITS'(SINE_N) : k_raw;

    // Output rounding by 2^12 or 2^15.
    assign rnd_l = prod_l_reg + (sh15_reg ? PROD_BITS'(1 << 14) : PROD_BITS'(1 << 11));
    assign rnd_r = prod_r_reg + (sh15_reg ? PROD_BITS'(1 << 14) : PROD_BITS'(1 << 11));
    assign sh_l  = sh15_reg ? (rnd_l >>> 15) : (rnd_l >>> 12);
    assign sh_r  = sh15_reg ? (rnd_r >>> 15) : (rnd_r >>> 12);

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PROD_BITS-1:0] v);
        logic signed [PROD_BITS-1:0] hi;
        logic signed [PROD_BITS-1:0] lo;
        hi = PROD_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - PROD_BITS'(1);
        if (v > hi)
            return SAMPLE_BITS'(hi);
        if (v < lo)
            return SAMPLE_BITS'(lo);
        return SAMPLE_BITS'(v);
    endfunction

    // Memory read address for the sequencer.
    always_comb
    begin
        case (state_reg)
            S_CHK0:  mem_addr = nm1;
            S_CHKL:  mem_addr = PIDX_BITS'(1);
            S_SCAN:  mem_addr = scan_idx_reg + 1'b1;
            default: mem_addr = '0;
        endcase
    end

    // Breakpoint memories: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            time_mem[point_index] <= point_time;
            val_mem[point_index]  <= point_value;
        end
        rd_t <= time_mem[mem_addr];
        rd_v <= val_mem[mem_addr];
    end

    // Next state and input stall.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (frame_acc)
                    state_next = (n_eff == '0) ? S_PROD : S_RD0;
            end
            S_RD0:
                state_next = S_CHK0;
            S_CHK0:
                if ((n_eff == CNT_BITS'(1)) || (cur_t_reg <= rd_t))
                    state_next = S_SCALE;
                else
                    state_next = S_CHKL;
            S_CHKL:
                if (cur_t_reg >= rd_t)
                    state_next = S_SCALE;
                else
                    state_next = S_SCAN;
            S_SCAN:
                if (seg_hit)
                    state_next = S_MULT;
                else if (scan_idx_reg == nm1)
                    state_next = S_SCALE;
            S_MULT:
                state_next = (d_reg == '0) ? S_SCALE : S_ABS;
            S_ABS:
                state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == QCNT_BITS'(QBITS - 1))
                    state_next = S_SCALE;
            S_SCALE:
                state_next = S_GAIN;
            S_GAIN:
                state_next = S_PROD;
            S_PROD:
                state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            intensity_reg <= INTENSITY_RESET;
            count_reg     <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_MODE:      mode_reg      <= pwdata[0];
                    REG_INTENSITY: intensity_reg <= pwdata[INT_BITS-1:0];
                    REG_COUNT:     count_reg     <= pwdata[CNT_BITS-1:0];
                    default:       ;
                endcase
            end
            if (frame_acc)
                frame_reg <= t_now + 1'b1;
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: search, interpolation, gain and scaling.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (frame_acc)
                begin
                    cur_t_reg  <= t_now;
                    l_reg      <= left_in;
                    r_reg      <= right_in;
                    gain_l_reg <= 20'sd4096;
                    gain_r_reg <= 20'sd4096;
                    sh15_reg   <= 1'b0;
                end
            end
            S_CHK0:
            begin
                prev_t_reg <= rd_t;
                prev_v_reg <= rd_v;
                env_reg    <= (VAL_BITS+1)'(rd_v);
            end
            S_CHKL:
            begin
                last_v_reg   <= rd_v;
                env_reg      <= (VAL_BITS+1)'(rd_v);
                scan_idx_reg <= PIDX_BITS'(1);
            end
            S_SCAN:
            begin
                if (seg_hit)
                begin
                    d_reg  <= rd_t - prev_t_reg;
                    dt_reg <= cur_t_reg - prev_t_reg;
                    dv_reg <= (VAL_BITS+1)'(rd_v) - (VAL_BITS+1)'(prev_v_reg);
                end
                else
                begin
                    prev_t_reg   <= rd_t;
                    prev_v_reg   <= rd_v;
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    env_reg      <= (VAL_BITS+1)'(last_v_reg);
                end
            end
            S_MULT:
            begin
                num_reg <= $signed({2'b00, dt_reg}) * dv_reg;
                env_reg <= (VAL_BITS+1)'(prev_v_reg);
            end
            S_ABS:
            begin
                neg_reg     <= num_reg < 0;
                rem_reg     <= num_abs[TIME_BITS+QBITS-1:QBITS];
                low_reg     <= num_abs[QBITS-1:0];
                q_reg       <= '0;
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg     <= div_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
                low_reg     <= {low_reg[QBITS-2:0], 1'b0};
                q_reg       <= q_next;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                env_reg     <= env_div;
            end
            S_SCALE:
                scale_reg <= ((VAL_BITS+2)'(env_reg) - (mode_reg ? 18'sd0 : 18'sd4096))
                             * $signed({1'b0, intensity_reg});
            S_GAIN:
            begin
                if (mode_reg)
                begin
                    gain_l_reg <= $signed({4'd0, SINE_TAB[KIDX_BITS'(SINE_N) - k_idx]});
                    gain_r_reg <= $signed({4'd0, SINE_TAB[k_idx]});
                    sh15_reg   <= 1'b1;
                end
                else
                begin
                    gain_l_reg <= amp_gain;
                    gain_r_reg <= amp_gain;
                    sh15_reg   <= 1'b0;
                end
            end
            S_PROD:
            begin
                prod_l_reg <= l_reg * gain_l_reg;
                prod_r_reg <= r_reg * gain_r_reg;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    left_out_reg  <= sat(sh_l);
                    right_out_reg <= sat(sh_r);
                end
            end
            default: ;
        endcase
    end

    // The divide never runs past its quotient width.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg < QCNT_BITS'(QBITS)))
        else $error("divide step count overrun");

    // The scan only visits entries below the point count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((scan_idx_reg <= nm1) && (n_eff > CNT_BITS'(1))))
        else $error("segment scan beyond point count");

    // A new output item only appears from the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output item without output stage");

    // The pan table index stays within the quarter wave.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GAIN) |-> (k_idx <= KIDX_BITS'(SINE_N)))
        else $error("pan table index out of range");

endmodule

`default_nettype wire
